// ----- src/dgs_pkg.sv -----
package dgs_pkg;

    // Fixed field widths
    localparam int SAMPLE_W = 12;
    localparam int VALUE_W  = SAMPLE_W + 1;
    localparam int OP_W     = 2;

    // Default sizing
    localparam int FIFO_DEPTH_DEF    = 16;
    localparam int WINDOW_LENGTH_DEF = 16;

    // Pointer placement after reset
    localparam int READ_START    = 6;
    localparam int LOOKAHEAD_GAP = 8;

    // Sample codes
    localparam logic [SAMPLE_W-1:0] SAT_CODE     = 12'hfff;
    localparam logic [SAMPLE_W-1:0] BASELINE_MAX = 12'd63;

    // Operation codes; code 3 is unused and ignored
    typedef enum logic [OP_W-1:0] {
        OP_WR_HIGH = 2'd0,
        OP_WR_LOW  = 2'd1,
        OP_READ    = 2'd2
    } op_t;

    // Registered read data from the sample store, with written flags
    typedef struct packed {
        logic [SAMPLE_W-1:0] hg;
        logic [SAMPLE_W-1:0] lg;
        logic [SAMPLE_W-1:0] look;
        logic                hg_ok;
        logic                lg_ok;
        logic                look_ok;
    } store_rd_t;

endpackage

// ----- src/dual_gain_select_fifo.sv -----
// A read word is registered in the store read registers, then in the result register.
// Throughput: one word per cycle; writes, reads and ignored codes back to back,
// while item_ready is high. Writes and ignored codes give no result word.
// Reset: write pointers 0, read pointer 6, look-ahead pointer 14 (mod depth),
// window count 0; every sample entry reads as zero until it is written.
module dual_gain_select_fifo #(
    parameter int FIFO_DEPTH    = dgs_pkg::FIFO_DEPTH_DEF,
    parameter int WINDOW_LENGTH = dgs_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic [dgs_pkg::OP_W-1:0]     operation,
    input  logic [dgs_pkg::SAMPLE_W-1:0] sample,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [dgs_pkg::VALUE_W-1:0]  selected_value,
    output logic                         baseline_flag
);
    import dgs_pkg::*;

    op_t       op;
    logic      accept;
    logic      wr_hi;
    logic      wr_lo;
    logic      rd;
    logic      s1_valid_reg;
    logic      s1_valid_next;
    logic      s1_adv;
    store_rd_t rd_data;

    // Operation decode on the accepted word
    assign op     = op_t'(operation);
    assign accept = item_valid && item_ready;
    assign wr_hi  = accept && (op == OP_WR_HIGH);
    assign wr_lo  = accept && (op == OP_WR_LOW);
    assign rd     = accept && (op == OP_READ);

    // Read stage moves on when the result register is free or being drained
    assign s1_adv     = s1_valid_reg && (!result_valid || result_ready);
    assign item_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rd)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    dgs_store #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_hi   (wr_hi),
        .wr_lo   (wr_lo),
        .rd      (rd),
        .wr_data (sample),
        .rd_data (rd_data)
    );

    dgs_select #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_select (
        .clk            (clk),
        .rst_n          (rst_n),
        .adv            (s1_adv),
        .rd_data        (rd_data),
        .result_ready   (result_ready),
        .result_valid   (result_valid),
        .selected_value (selected_value),
        .baseline_flag  (baseline_flag)
    );

`ifndef SYNTH
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> s1_valid_reg && result_valid)
        else $error("input stalled with a free pipeline");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && result_valid && !result_ready |=> s1_valid_reg)
        else $error("read stage word dropped under stall");

    a_read_enters: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (operation == OP_READ) |=> s1_valid_reg)
        else $error("accepted read word missing from read stage");
`endif

endmodule

// ----- src/dgs_store.sv -----
module dgs_store #(
    parameter int FIFO_DEPTH = dgs_pkg::FIFO_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_hi,
    input  logic                        wr_lo,
    input  logic                        rd,
    input  logic [dgs_pkg::SAMPLE_W-1:0] wr_data,
    output dgs_pkg::store_rd_t          rd_data
);
    import dgs_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam logic [AW-1:0] LAST_IDX  = AW'(FIFO_DEPTH - 1);
    localparam logic [AW-1:0] RD_INIT   = AW'(READ_START % FIFO_DEPTH);
    localparam logic [AW-1:0] LOOK_INIT = AW'((READ_START + LOOKAHEAD_GAP) % FIFO_DEPTH);

    // Wrapping increment
    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    logic [SAMPLE_W-1:0] hg_mem_reg [FIFO_DEPTH];
    logic [SAMPLE_W-1:0] lg_mem_reg [FIFO_DEPTH];
    logic [FIFO_DEPTH-1:0] hg_ok_reg;
    logic [FIFO_DEPTH-1:0] lg_ok_reg;

    logic [AW-1:0] hg_wr_ptr_reg;
    logic [AW-1:0] lg_wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] look_ptr_reg;

    logic [SAMPLE_W-1:0] hg_rd_reg;
    logic [SAMPLE_W-1:0] lg_rd_reg;
    logic [SAMPLE_W-1:0] look_rd_reg;
    logic                hg_ok_rd_reg;
    logic                lg_ok_rd_reg;
    logic                look_ok_rd_reg;

    // Pointers and written flags; an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hg_wr_ptr_reg <= '0;
            lg_wr_ptr_reg <= '0;
            rd_ptr_reg    <= RD_INIT;
            look_ptr_reg  <= LOOK_INIT;
            hg_ok_reg     <= '0;
            lg_ok_reg     <= '0;
        end
        else
        begin
            if (wr_hi)
            begin
                hg_ok_reg[hg_wr_ptr_reg] <= 1'b1;
                hg_wr_ptr_reg            <= wrap_inc(hg_wr_ptr_reg);
            end
            if (wr_lo)
            begin
                lg_ok_reg[lg_wr_ptr_reg] <= 1'b1;
                lg_wr_ptr_reg            <= wrap_inc(lg_wr_ptr_reg);
            end
            if (rd)
            begin
                rd_ptr_reg   <= wrap_inc(rd_ptr_reg);
                look_ptr_reg <= wrap_inc(look_ptr_reg);
            end
        end
    end

    // High-gain memory: one write port, two read ports
    always_ff @(posedge clk)
    begin
        if (wr_hi)
        begin
            hg_mem_reg[hg_wr_ptr_reg] <= wr_data;
        end
        if (rd)
        begin
            hg_rd_reg   <= hg_mem_reg[rd_ptr_reg];
            look_rd_reg <= hg_mem_reg[look_ptr_reg];
        end
    end

    // Low-gain memory: one write port, one read port
    always_ff @(posedge clk)
    begin
        if (wr_lo)
        begin
            lg_mem_reg[lg_wr_ptr_reg] <= wr_data;
        end
        if (rd)
        begin
            lg_rd_reg <= lg_mem_reg[rd_ptr_reg];
        end
    end

    // Written flags travel with the read data
    always_ff @(posedge clk)
    begin
        if (rd)
        begin
            hg_ok_rd_reg   <= hg_ok_reg[rd_ptr_reg];
            lg_ok_rd_reg   <= lg_ok_reg[rd_ptr_reg];
            look_ok_rd_reg <= hg_ok_reg[look_ptr_reg];
        end
    end

    assign rd_data.hg      = hg_rd_reg;
    assign rd_data.lg      = lg_rd_reg;
    assign rd_data.look    = look_rd_reg;
    assign rd_data.hg_ok   = hg_ok_rd_reg;
    assign rd_data.lg_ok   = lg_ok_rd_reg;
    assign rd_data.look_ok = look_ok_rd_reg;

endmodule

// ----- src/dgs_select.sv -----
module dgs_select #(
    parameter int WINDOW_LENGTH = dgs_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  dgs_pkg::store_rd_t           rd_data,
    input  logic                         result_ready,
    output logic                         result_valid,
    output logic [dgs_pkg::VALUE_W-1:0]  selected_value,
    output logic                         baseline_flag
);
    import dgs_pkg::*;

    localparam int WW = $clog2(WINDOW_LENGTH + 1);
    localparam logic [WW-1:0] WIN_LOAD = WW'(WINDOW_LENGTH);

    logic [WW-1:0]       window_reg;
    logic [WW-1:0]       window_next;
    logic [WW-1:0]       win_loaded;
    logic                valid_reg;
    logic                valid_next;
    logic [VALUE_W-1:0]  value_reg;
    logic [VALUE_W-1:0]  value_next;
    logic                flag_reg;
    logic                flag_next;
    logic [SAMPLE_W-1:0] hg;
    logic [SAMPLE_W-1:0] lg;
    logic [SAMPLE_W-1:0] look;
    logic                use_low;

    // Unwritten entries read as zero
    assign hg   = rd_data.hg_ok   ? rd_data.hg   : '0;
    assign lg   = rd_data.lg_ok   ? rd_data.lg   : '0;
    assign look = rd_data.look_ok ? rd_data.look : '0;

    // Saturation ahead (re)loads the window; the window picks low gain
    always_comb
    begin
        win_loaded = (look == SAT_CODE) ? WIN_LOAD : window_reg;
        use_low    = (win_loaded != '0);
        value_next = use_low ? {1'b1, lg} : {1'b0, hg};
        flag_next  = !use_low && (hg <= BASELINE_MAX);
        window_next = window_reg;
        if (adv)
        begin
            window_next = use_low ? win_loaded - 1'b1 : '0;
        end
        valid_next = valid_reg;
        if (adv)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Window count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            window_reg <= window_next;
            valid_reg  <= valid_next;
        end
    end

    // Result word register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg <= value_next;
            flag_reg  <= flag_next;
        end
    end

    assign result_valid   = valid_reg;
    assign selected_value = value_reg;
    assign baseline_flag  = flag_reg;

`ifndef SYNTH
    a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
        window_reg <= WIN_LOAD)
        else $error("window count above its load value");

    a_low_no_flag: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && selected_value[VALUE_W-1] |-> !baseline_flag)
        else $error("baseline flag set on a low-gain word");
`endif

endmodule

// ----- bench/tb_top.sv -----
module tb_top;
    import dgs_pkg::*;

    localparam int DEPTH       = FIFO_DEPTH_DEF;
    localparam int WINDOW      = WINDOW_LENGTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_WORDS = 650;
    localparam int DIR_N       = 25;

    // Unused operation code; the block drops it
    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               flag;
    } pick_t;

    // Directed row: word to send, plus an optional typed-in result
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SAMPLE_W-1:0] smp;
        logic                typed;
        logic [VALUE_W-1:0]  value;
        logic                flag;
    } row_t;

    localparam row_t DIRECTED_ROWS [DIR_N] = '{
        '{OP_READ,    12'h000, 1'b1, 13'h0000, 1'b1},  // cleared store reads zero
        '{OP_IGNORED, 12'hfff, 1'b0, 13'h0000, 1'b0},  // unused code, no result
        '{OP_READ,    12'hfff, 1'b1, 13'h0000, 1'b1},  // sample bits ignored on read
        '{OP_WR_HIGH, 12'hfff, 1'b0, 13'h0000, 1'b0},
        '{OP_WR_HIGH, 12'h000, 1'b0, 13'h0000, 1'b0},
        '{OP_WR_HIGH, 12'h03f, 1'b0, 13'h0000, 1'b0},  // baseline edge
        '{OP_WR_HIGH, 12'h040, 1'b0, 13'h0000, 1'b0},  // just above baseline
        '{OP_WR_LOW,  12'hfff, 1'b0, 13'h0000, 1'b0},
        '{OP_WR_LOW,  12'h000, 1'b0, 13'h0000, 1'b0},
        '{OP_WR_LOW,  12'h555, 1'b0, 13'h0000, 1'b0},
        '{OP_WR_HIGH, 12'hfff, 1'b0, 13'h0000, 1'b0},  // second saturation
        '{OP_READ,    12'h000, 1'b0, 13'h0000, 1'b0},  // look-ahead hits saturation
        '{OP_READ,    12'h000, 1'b0, 13'h0000, 1'b0},
        '{OP_READ,    12'haaa, 1'b0, 13'h0000, 1'b0},
        '{OP_READ,    12'h000, 1'b0, 13'h0000, 1'b0},
        '{OP_READ,    12'h000, 1'b0, 13'h0000, 1'b0},  // window reloaded while running
        '{OP_WR_LOW,  12'haaa, 1'b0, 13'h0000, 1'b0},
        '{OP_WR_HIGH, 12'h7ff, 1'b0, 13'h0000, 1'b0},
        '{OP_READ,    12'h000, 1'b0, 13'h0000, 1'b0},
        '{OP_READ,    12'h000, 1'b0, 13'h0000, 1'b0},
        '{OP_IGNORED, 12'h000, 1'b0, 13'h0000, 1'b0},
        '{OP_READ,    12'h000, 1'b0, 13'h0000, 1'b0},
        '{OP_WR_HIGH, 12'h800, 1'b0, 13'h0000, 1'b0},
        '{OP_READ,    12'h000, 1'b0, 13'h0000, 1'b0},
        '{OP_READ,    12'h000, 1'b0, 13'h0000, 1'b0}
    };

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    logic [OP_W-1:0]     operation;
    logic [SAMPLE_W-1:0] sample;
    logic                result_valid;
    logic                result_ready;
    logic [VALUE_W-1:0]  selected_value;
    logic                baseline_flag;

    // Mirror of the block state
    logic [SAMPLE_W-1:0] hg_mirror [DEPTH];
    logic [SAMPLE_W-1:0] lg_mirror [DEPTH];
    int                  hg_wr_ptr;
    int                  lg_wr_ptr;
    int                  rd_ptr;
    int                  look_ptr;
    int                  window_left;

    pick_t pending_picks [$];
    int    error_count;
    int    cycle_count;
    int    send_idle_pct;
    int    recv_idle_pct;
    int    sat_pct;

    dual_gain_select_fifo dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .operation      (operation),
        .sample         (sample),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .selected_value (selected_value),
        .baseline_flag  (baseline_flag)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int wrap_next(input int idx);
        return (idx == DEPTH - 1) ? 0 : idx + 1;
    endfunction

    // Update the mirror with one word; returns 1 when a result word is due
    function automatic bit select_sample(input logic [OP_W-1:0] op,
                                         input logic [SAMPLE_W-1:0] smp,
                                         output pick_t pick);
        logic [SAMPLE_W-1:0] hg;
        logic [SAMPLE_W-1:0] lg;
        logic [SAMPLE_W-1:0] ahead;
        pick = '0;
        case (op)
            OP_WR_HIGH:
            begin
                hg_mirror[hg_wr_ptr] = smp;
                hg_wr_ptr = wrap_next(hg_wr_ptr);
                return 1'b0;
            end
            OP_WR_LOW:
            begin
                lg_mirror[lg_wr_ptr] = smp;
                lg_wr_ptr = wrap_next(lg_wr_ptr);
                return 1'b0;
            end
            OP_READ:
            begin
                hg    = hg_mirror[rd_ptr];
                lg    = lg_mirror[rd_ptr];
                ahead = hg_mirror[look_ptr];
                rd_ptr   = wrap_next(rd_ptr);
                look_ptr = wrap_next(look_ptr);
                if (ahead == SAT_CODE)
                    window_left = WINDOW;
                if (window_left != 0)
                begin
                    window_left--;
                    pick.value = {1'b1, lg};
                    pick.flag  = 1'b0;
                end
                else
                begin
                    pick.value = {1'b0, hg};
                    pick.flag  = (hg <= BASELINE_MAX);
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // Present one word, wait for acceptance, then record what it should give
    task automatic send_word(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp,
                             input logic typed, input logic [VALUE_W-1:0] tvalue,
                             input logic tflag);
        pick_t pick;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        operation  <= op;
        sample     <= smp;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        if (select_sample(op, smp, pick))
        begin
            if (typed)
            begin
                pick.value = tvalue;
                pick.flag  = tflag;
            end
            pending_picks.push_back(pick);
        end
    endtask

    // Hold the sender off until every pending result has come back
    task automatic drain_results();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_picks.size() != 0);
    endtask

    function automatic logic [OP_W-1:0] draw_op();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return OP_IGNORED;
        if (r < 38)
            return OP_WR_HIGH;
        if (r < 62)
            return OP_WR_LOW;
        return OP_READ;
    endfunction

    // Samples weighted toward saturation and the baseline edge
    function automatic logic [SAMPLE_W-1:0] draw_sample();
        int r;
        r = $urandom_range(99);
        if (r < sat_pct)
            return SAT_CODE;
        r = $urandom_range(99);
        if (r < 6)
            return '0;
        if (r < 12)
            return BASELINE_MAX;
        if (r < 18)
            return SAMPLE_W'(BASELINE_MAX + 1);
        if (r < 35)
            return SAMPLE_W'($urandom_range(63));
        return SAMPLE_W'($urandom_range(4095));
    endfunction

    task automatic run_phase(input int sidle, input int ridle);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int n = 0; n < PHASE_WORDS; n++)
        begin
            // saturation density changes every 64 words: quiet stretches and windows
            if (n % 64 == 0)
            begin
                case ($urandom_range(3))
                    0: sat_pct = 0;
                    1: sat_pct = 3;
                    2: sat_pct = 10;
                    default: sat_pct = 30;
                endcase
            end
            send_word(draw_op(), draw_sample(), 1'b0, '0, 1'b0);
        end
        drain_results();
    endtask

    // Result checker and receiver stalls
    always @(posedge clk)
    begin
        pick_t due;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_picks.size() == 0)
            begin
                $error("result word with nothing pending: selected_value %h baseline_flag %b",
                       selected_value, baseline_flag);
                error_count++;
            end
            else
            begin
                due = pending_picks.pop_front();
                if (selected_value !== due.value)
                begin
                    $error("selected_value: expected %h, got %h", due.value, selected_value);
                    error_count++;
                end
                if (baseline_flag !== due.flag)
                begin
                    $error("baseline_flag: expected %b, got %b", due.flag, baseline_flag);
                    error_count++;
                end
            end
        end
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        item_valid    = 1'b0;
        operation     = OP_WR_HIGH;
        sample        = '0;
        result_ready  = 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        send_idle_pct = 7;
        recv_idle_pct = 63;
        sat_pct       = 10;

        // mirror reset: stores cleared, read pointer 6, look-ahead 8 ahead
        for (int i = 0; i < DEPTH; i++)
        begin
            hg_mirror[i] = '0;
            lg_mirror[i] = '0;
        end
        hg_wr_ptr   = 0;
        lg_wr_ptr   = 0;
        rd_ptr      = READ_START % DEPTH;
        look_ptr    = (READ_START + LOOKAHEAD_GAP) % DEPTH;
        window_left = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < DIR_N; i++)
            send_word(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].flag);
        drain_results();

        // random words: sender light / receiver heavy, swapped, then no idling
        run_phase(7, 63);
        run_phase(63, 7);
        run_phase(0, 0);

        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_picks.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
src/dgs_pkg.sv
src/dgs_store.sv
src/dgs_select.sv
src/dual_gain_select_fifo.sv
bench/tb_top.sv
